// ----- rtl/rdq_pkg.sv -----
package rdq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam logic [6:0] ThresholdReset = 7'd50;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd1;
  localparam logic [2:0] REQ_POP_BACK   = 3'd2;
  localparam logic [2:0] REQ_SEARCH     = 3'd3;
  localparam logic [2:0] REQ_DUMP       = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic        pass;
    logic [6:0]  score;
    logic [31:0] id;
  } record_t;

  localparam record_t RecordZero = '0;

endpackage

// ----- rtl/rdq_mem.sv -----
module rdq_mem
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [PW-1:0] wr_addr_i,
  input  record_t       wr_data_i,
  input  logic          rd_en_i,
  input  logic [PW-1:0] rd_addr_i,
  output record_t       rd_data_o
);

  record_t mem_q [DEPTH];
  record_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds until the next read, so a stalled result keeps it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/rdq_ctrl.sv -----
module rdq_ctrl
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    in_req_i,
  input  logic [31:0]   in_key_i,
  input  logic [6:0]    in_score_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output status_e       out_status_o,
  output record_t       out_rec_o,
  output logic          out_last_o,
  output logic          mem_wr_en_o,
  output logic [PW-1:0] mem_wr_addr_o,
  output record_t       mem_wr_data_o,
  output logic          mem_rd_en_o,
  output logic [PW-1:0] mem_rd_addr_o,
  input  record_t       mem_rd_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_SCAN = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [6:0]    thresh_q;
  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [PW-1:0] slot_q, slot_d;
  logic [2:0]    req_q;
  logic [31:0]   key_q;
  logic [6:0]    score_q;

  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  record_t       out_rec_q, out_rec_d;
  logic          out_last_q, out_last_d;

  logic          out_free;
  logic          is_empty;
  logic          is_full;
  logic          in_xfer;
  logic [PW-1:0] push_slot;
  logic [PW-1:0] next_slot;
  logic [PW:0]   back_sum;
  logic [PW-1:0] back_slot;
  logic          scan_done;

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CW'(DEPTH));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer   = in_valid_i && in_ready_o;
  assign push_slot = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign next_slot = (slot_q == PW'(DEPTH - 1)) ? '0 : slot_q + PW'(1);
  assign back_sum  = {1'b0, front_q} + (PW + 1)'(count_q - CW'(1));
  assign back_slot = (back_sum >= (PW + 1)'(DEPTH)) ?
                     PW'(back_sum - (PW + 1)'(DEPTH)) : PW'(back_sum);
  assign scan_done = ((idx_q + CW'(1)) == count_q);

  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    count_d       = count_q;
    idx_d         = idx_q;
    slot_d        = slot_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_rec_d     = out_rec_q;
    out_last_d    = out_last_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = push_slot;
    mem_wr_data_o = '{pass: (score_q >= thresh_q), score: score_q, id: key_q};
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = front_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          priority if (req_q == REQ_PUSH_FRONT) begin
            out_valid_d = 1'b1;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
            if (is_full) begin
              out_status_d = STATUS_FULL;
              out_rec_d    = RecordZero;
            end else begin
              mem_wr_en_o  = 1'b1;
              front_d      = push_slot;
              count_d      = count_q + CW'(1);
              out_status_d = STATUS_OK;
              out_rec_d    = mem_wr_data_o;
            end
          end else if (req_q == REQ_POP_FRONT || req_q == REQ_POP_BACK ||
                       req_q == REQ_SEARCH || req_q == REQ_DUMP) begin
            if (is_empty) begin
              out_valid_d  = 1'b1;
              out_last_d   = 1'b1;
              out_status_d = STATUS_EMPTY;
              out_rec_d    = RecordZero;
              state_d      = ST_IDLE;
            end else begin
              mem_rd_en_o = 1'b1;
              idx_d       = '0;
              slot_d      = front_q;
              if (req_q == REQ_POP_FRONT) begin
                front_d = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
                count_d = count_q - CW'(1);
                state_d = ST_READ;
              end else if (req_q == REQ_POP_BACK) begin
                mem_rd_addr_o = back_slot;
                count_d       = count_q - CW'(1);
                state_d       = ST_READ;
              end else begin
                state_d = ST_SCAN;
              end
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_status_d = STATUS_OK;
          out_rec_d    = mem_rd_data_i;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (req_q == REQ_SEARCH) begin
          if (mem_rd_data_i.id == key_q) begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_last_d   = 1'b1;
              out_status_d = STATUS_OK;
              out_rec_d    = mem_rd_data_i;
              state_d      = ST_IDLE;
            end
          end else if (scan_done) begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_last_d   = 1'b1;
              out_status_d = STATUS_NOT_FOUND;
              out_rec_d    = RecordZero;
              state_d      = ST_IDLE;
            end
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = next_slot;
            slot_d        = next_slot;
            idx_d         = idx_q + CW'(1);
          end
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = scan_done;
          out_status_d = STATUS_OK;
          out_rec_d    = mem_rd_data_i;
          if (scan_done) begin
            state_d = ST_IDLE;
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = next_slot;
            slot_d        = next_slot;
            idx_d         = idx_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thresh_q    <= ThresholdReset;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q   <= in_req_i;
      key_q   <= in_key_i;
      score_q <= in_score_i;
    end
    out_status_q <= out_status_d;
    out_rec_q    <= out_rec_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_rec_o    = out_rec_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/record_deque_with_key_search_top.sv -----
// Bounded deque of records (id, score, pass flag) with search by id.
// Requests arrive on the s_axis channel: tuser carries the request code
// (push front, remove front, remove back, search, dump) and tdata the id and
// score. Results leave on the m_axis channel: tuser carries the status, tdata
// the record, and tlast marks the final result of a request.
// A request is taken only while the controller is idle. A push and a
// rejected request give their result from the execute state; a remove reads
// the memory there and gives its result from the read state. A search visits
// one stored entry per cycle through the single memory read port; a dump
// gives one result per cycle while the receiver keeps tready high.
// Unused request codes give no result and return the controller to idle.
// When the receiver stalls, the result waits in the output register and a
// dump's walk through the memory pauses until it is taken.
// The pass threshold is written through cfg_we_i and cfg_wdata_i.
// Reset empties the store at once and sets the threshold to 50; record
// contents are not cleared.
module record_deque_with_key_search_top
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: key_id[31:0], score[38:32], zero pad[39].
  input  logic [39:0] s_axis_tdata,
  // Fields from bit 0: req_type[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: rec_id[31:0], rec_score[38:32], rec_pass[39].
  output logic [39:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic          mem_wr_en;
  logic [PW-1:0] mem_wr_addr;
  record_t       mem_wr_data;
  logic          mem_rd_en;
  logic [PW-1:0] mem_rd_addr;
  record_t       mem_rd_data;
  status_e       out_status;
  record_t       out_rec;

  rdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_req_i     (s_axis_tuser),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_score_i   (s_axis_tdata[38:32]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_rec_o    (out_rec),
    .out_last_o   (m_axis_tlast),
    .mem_wr_en_o  (mem_wr_en),
    .mem_wr_addr_o(mem_wr_addr),
    .mem_wr_data_o(mem_wr_data),
    .mem_rd_en_o  (mem_rd_en),
    .mem_rd_addr_o(mem_rd_addr),
    .mem_rd_data_i(mem_rd_data)
  );

  rdq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  assign m_axis_tdata = out_rec;
  assign m_axis_tuser = out_status;

endmodule

// ----- tb/tb_record_deque_with_key_search_top.sv -----
`timescale 1ns / 100ps

module tb_record_deque_with_key_search_top;
  import rdq_pkg::*;

  localparam int unsigned Depth = DepthDefault;
  localparam int unsigned MaxGap = 18;

  typedef struct {
    status_e     status;
    logic [31:0] id;
    logic [6:0]  score;
    logic        pass;
    logic        last;
  } deque_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [31:0] store_id [Depth];
  logic [6:0]  store_score [Depth];
  logic        store_pass [Depth];
  int unsigned head;
  int unsigned fill;
  logic [6:0]  pass_thr;

  deque_result_t expected_results[$];

  int unsigned errors;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_not_found;
  int unsigned n_thresholds;
  int unsigned hold_request;
  bit          no_idle;

  record_deque_with_key_search_top #(
    .DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("** record_deque_with_key_search_top: FAILED **");
    $finish;
  end

  function automatic void note_result(status_e status, logic [31:0] id, logic [6:0] score,
                                      logic pass, logic last);
    deque_result_t r;
    r.status = status;
    r.id     = id;
    r.score  = score;
    r.pass   = pass;
    r.last   = last;
    expected_results.push_back(r);
    case (status)
      STATUS_FULL:      n_full++;
      STATUS_EMPTY:     n_empty++;
      STATUS_NOT_FOUND: n_not_found++;
      default: ;
    endcase
  endfunction

  function automatic int unsigned slot_of(int unsigned offset);
    return (head + offset) % Depth;
  endfunction

  function automatic void note_slot(int unsigned slot, logic last);
    note_result(STATUS_OK, store_id[slot], store_score[slot], store_pass[slot], last);
  endfunction

  // Updates the deque image for one accepted request and queues its results.
  function automatic void predict_request(logic [2:0] req, logic [31:0] key, logic [6:0] score);
    int unsigned slot;
    bit          found;
    found = 1'b0;
    if (req <= REQ_DUMP) begin
      n_requests++;
    end
    case (req)
      REQ_PUSH_FRONT: begin
        if (fill >= Depth) begin
          note_result(STATUS_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          head = (head + Depth - 1) % Depth;
          store_id[head]    = key;
          store_score[head] = score;
          store_pass[head]  = (score >= pass_thr);
          fill++;
          note_slot(head, 1'b1);
        end
      end
      REQ_POP_FRONT: begin
        if (fill == 0) begin
          note_result(STATUS_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          note_slot(head, 1'b1);
          head = (head + 1) % Depth;
          fill--;
        end
      end
      REQ_POP_BACK: begin
        if (fill == 0) begin
          note_result(STATUS_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          note_slot(slot_of(fill - 1), 1'b1);
          fill--;
        end
      end
      REQ_SEARCH: begin
        if (fill == 0) begin
          note_result(STATUS_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++) begin
            slot = slot_of(i);
            if (!found && store_id[slot] == key) begin
              note_slot(slot, 1'b1);
              found = 1'b1;
            end
          end
          if (!found) begin
            note_result(STATUS_NOT_FOUND, '0, '0, 1'b0, 1'b1);
          end
        end
      end
      REQ_DUMP: begin
        if (fill == 0) begin
          note_result(STATUS_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++) begin
            note_slot(slot_of(i), (i + 1 == fill));
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_result();
    deque_result_t e;
    n_results++;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: status %0d id %h", m_axis_tuser, m_axis_tdata[31:0]);
      errors++;
    end else begin
      e = expected_results.pop_front();
      if (m_axis_tuser !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, m_axis_tuser);
        errors++;
      end
      if (m_axis_tdata[31:0] !== e.id) begin
        $error("rec_id: expected %h, actual %h", e.id, m_axis_tdata[31:0]);
        errors++;
      end
      if (m_axis_tdata[38:32] !== e.score) begin
        $error("rec_score: expected %0d, actual %0d", e.score, m_axis_tdata[38:32]);
        errors++;
      end
      if (m_axis_tdata[39] !== e.pass) begin
        $error("rec_pass: expected %0d, actual %0d", e.pass, m_axis_tdata[39]);
        errors++;
      end
      if (m_axis_tlast !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, m_axis_tlast);
        errors++;
      end
    end
  endtask

  // Result side: checks every transfer and draws the stall before the next one.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        check_result();
        stall_left = no_idle ? 0 : $urandom_range(0, MaxGap);
      end
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic issue_request(logic [2:0] req, logic [31:0] key, logic [6:0] score);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, score, key};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(req, key, score);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [6:0] value);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pass_thr = value;
    n_thresholds++;
  endtask

  task automatic issue_random(int unsigned push_pct, output bit counted);
    logic [2:0]  req;
    logic [31:0] key;
    logic [6:0]  score;
    int unsigned pick;
    key   = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
    score = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                        : 7'($urandom_range(0, 100));
    if ($urandom_range(0, 99) < push_pct) begin
      req = REQ_PUSH_FRONT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        req = REQ_POP_FRONT;
      end else if (pick < 10) begin
        req = REQ_POP_BACK;
      end else if (pick < 16) begin
        req = REQ_SEARCH;
        if (fill > 0 && $urandom_range(0, 3) != 0) begin
          key = store_id[slot_of($urandom_range(0, fill - 1))];
        end
      end else if (pick < 19) begin
        req = REQ_DUMP;
      end else begin
        req = 3'($urandom_range(REQ_DUMP + 1, 7));
      end
    end
    counted = (req <= REQ_DUMP);
    issue_request(req, key, score);
  endtask

  task automatic test_empty_store();
    issue_request(REQ_POP_FRONT, 32'hFFFF_FFFF, 7'd127);
    issue_request(REQ_POP_BACK, 32'h0, 7'd0);
    issue_request(REQ_SEARCH, 32'h1234_5678, 7'd0);
    issue_request(REQ_DUMP, 32'h0, 7'd0);
  endtask

  task automatic test_unused_codes();
    for (int unsigned c = REQ_DUMP + 1; c <= 7; c++) begin
      issue_request(3'(c), $urandom, 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic test_push_search_dump();
    issue_request(REQ_PUSH_FRONT, 32'h0, 7'd0);
    issue_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 7'd127);
    issue_request(REQ_PUSH_FRONT, 32'h0000_0005, pass_thr);
    issue_request(REQ_PUSH_FRONT, 32'h0000_0005, pass_thr - 7'd1);
    issue_request(REQ_PUSH_FRONT, 32'hA5A5_5A5A, 7'd100);
    issue_request(REQ_SEARCH, 32'h0, 7'd0);
    issue_request(REQ_SEARCH, 32'h0000_0005, 7'd0);
    issue_request(REQ_SEARCH, 32'hA5A5_5A5A, 7'd0);
    issue_request(REQ_SEARCH, 32'hDEAD_BEEF, 7'd0);
    issue_request(REQ_DUMP, 32'h0, 7'd0);
    issue_request(REQ_POP_BACK, 32'h0, 7'd0);
    issue_request(REQ_POP_FRONT, 32'h0, 7'd0);
    issue_request(REQ_DUMP, 32'h0, 7'd0);
  endtask

  task automatic test_random_mix(int unsigned n_items, int unsigned push_pct, bit fast);
    int unsigned sent;
    bit          counted;
    sent    = 0;
    no_idle = fast;
    while (sent < n_items) begin
      if (!fast && $urandom_range(0, 39) == 0) begin
        no_idle = ~no_idle;
      end
      issue_random(push_pct, counted);
      if (counted) begin
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // The result side holds off while requests keep coming, so the block backs up.
  task automatic test_output_backpressure();
    int unsigned sent;
    bit          counted;
    sent = 0;
    @(posedge clk_i);
    hold_request = 300;
    no_idle      = 1'b1;
    while (sent < 30) begin
      issue_random(50, counted);
      if (counted) begin
        sent++;
      end
    end
    no_idle = 1'b0;
    wait_quiet();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    hold_request  = 0;
    no_idle       = 1'b0;
    errors        = 0;
    n_requests    = 0;
    n_results     = 0;
    n_full        = 0;
    n_empty       = 0;
    n_not_found   = 0;
    n_thresholds  = 1;
    head          = 0;
    fill          = 0;
    pass_thr      = ThresholdReset;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_unused_codes();
    test_push_search_dump();
    test_random_mix(60, 70, 1'b0);
    write_threshold(7'd0);
    test_random_mix(55, 35, 1'b1);
    write_threshold(7'd127);
    test_random_mix(55, 50, 1'b0);
    test_output_backpressure();
    write_threshold(7'd100);
    test_random_mix(55, 25, 1'b0);
    write_threshold(7'($urandom_range(1, 99)));
    test_random_mix(55, 55, 1'b0);
    write_threshold(ThresholdReset);
    test_random_mix(25, 45, 1'b0);
    wait_quiet();

    $display("Run covered %0d requests and %0d results under %0d threshold settings,",
             n_requests, n_results, n_thresholds);
    $display("with %0d full, %0d empty and %0d not-found reports.",
             n_full, n_empty, n_not_found);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** record_deque_with_key_search_top: PASSED **");
    end else begin
      $display("** record_deque_with_key_search_top: FAILED **");
    end
    $finish;
  end

endmodule
